/* design/lle_pkg.sv */
package lle_pkg;

	// Default sizes of the grading lists and of the fixed-point fraction.
	localparam int CPU_ROWS_DEF  = 5;
	localparam int GPU_ROWS_DEF  = 9;
	localparam int FRAC_BITS_DEF = 16;

	// A row index runs from 0 up to and including the largest row count.
	localparam int MAX_ROWS = 16;
	localparam int IDX_W    = $clog2(MAX_ROWS + 1);

	// Field widths of the counts and of the reported levels.
	localparam int BRK_W        = 16;
	localparam int NODE_W       = 16;
	localparam int PARTICLE_W   = 16;
	localparam int ACTION_W     = 16;
	localparam int AUDIO_W      = 10;
	localparam int VERTEX_W     = 20;
	localparam int DRAW_W       = 16;
	localparam int PROC_GRADE_W = 3;
	localparam int GFX_GRADE_W  = 4;
	localparam int STATE_W      = 4;

	// Marker held in the reported-level registers while nothing is reported.
	localparam logic [STATE_W-1:0] NONE_REPORTED = 4'hf;

	localparam int CPU_COLS = 4;
	localparam int GPU_COLS = 2;
	localparam int CPU_LIST = 5;
	localparam int GPU_LIST = 9;

	// Column numbers of the breakpoint lists.
	localparam int COL_NODE     = 0;
	localparam int COL_PARTICLE = 1;
	localparam int COL_ACTION   = 2;
	localparam int COL_AUDIO    = 3;
	localparam int COL_VERTEX   = 0;
	localparam int COL_DRAW     = 1;

	typedef enum logic {
		TAB_CPU = 1'b0,
		TAB_GPU = 1'b1
	} tab_t;

	// Ascending breakpoints, one list per activity count.
	localparam logic [BRK_W-1:0] CPU_BRK [CPU_COLS][CPU_LIST] = '{
		'{16'd500, 16'd1250, 16'd1750, 16'd2750, 16'd4000},
		'{16'd500, 16'd1500, 16'd2000, 16'd2500, 16'd3500},
		'{16'd500, 16'd2000, 16'd3000, 16'd7000, 16'd10000},
		'{16'd6,   16'd20,   16'd32,   16'd50,   16'd80}
	};

	localparam logic [BRK_W-1:0] GPU_BRK [GPU_COLS][GPU_LIST] = '{
		'{16'd2000, 16'd4000, 16'd6000, 16'd8000, 16'd10000,
		  16'd15000, 16'd22000, 16'd30000, 16'd40000},
		'{16'd400, 16'd800, 16'd1000, 16'd1100, 16'd1200,
		  16'd1300, 16'd1350, 16'd1400, 16'd1450}
	};

	// Breakpoint of one row; rows past the end of a list repeat its last entry.
	function automatic logic [BRK_W-1:0] brk_at(input tab_t tab, input int col,
		input int row);
		int r;
		r = (row < 0) ? 0 : row;
		if (tab == TAB_CPU) begin
			r = (r < CPU_LIST) ? r : CPU_LIST - 1;
			return CPU_BRK[col][r];
		end else begin
			r = (r < GPU_LIST) ? r : GPU_LIST - 1;
			return GPU_BRK[col][r];
		end
	endfunction

	// Widest span between neighboring breakpoints among the first rows.
	function automatic int max_step(input tab_t tab, input int col, input int rows);
		int best;
		int prev;
		int cur;
		best = 1;
		prev = 0;
		for (int r = 0; r < rows; r++) begin
			cur = int'(brk_at(tab, col, r));
			if (cur - prev > best) begin
				best = cur - prev;
			end
			prev = cur;
		end
		return best;
	endfunction

endpackage

/* design/lle_factor.sv */
module lle_factor #(
	parameter lle_pkg::tab_t TAB       = lle_pkg::TAB_CPU,
	parameter int            COL       = 0,
	parameter int            ROWS      = lle_pkg::CPU_ROWS_DEF,
	parameter int            FRAC_BITS = lle_pkg::FRAC_BITS_DEF,
	parameter int            VALUE_W   = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [VALUE_W-1:0]                    value,
	output logic [lle_pkg::IDX_W+FRAC_BITS-1:0]   factor_s2
);
	import lle_pkg::*;

	// Every offset into a span lies below the widest span, so it fits in STEP_L bits.
	localparam int STEP_MAX = max_step(TAB, COL, ROWS);
	localparam int STEP_L   = (STEP_MAX <= 1) ? 1 : $clog2(STEP_MAX);
	// With a reciprocal scaled by 2**(FRAC_BITS + SHIFT) the truncated quotient is
	// exact for every offset below its span.
	localparam int SHIFT    = 2 * STEP_L;
	localparam int M_W      = FRAC_BITS + SHIFT + 1;
	localparam int P_W      = STEP_L + M_W;
	localparam int CMP_W    = (VALUE_W > BRK_W) ? VALUE_W : BRK_W;

	logic [ROWS-1:0]      below;
	logic [ROWS-1:0]      first;
	logic [CMP_W-1:0]     base_r [ROWS];
	logic [M_W-1:0]       recip_r [ROWS];
	logic [CMP_W-1:0]     base;
	logic [M_W-1:0]       recip;
	logic [IDX_W-1:0]     idx;
	logic [CMP_W-1:0]     diff;
	logic [P_W-1:0]       product;
	logic [FRAC_BITS-1:0] quot;

	// Per row: compare against the breakpoint and hold the span constants.
	for (genvar r = 0; r < ROWS; r++) begin : g_row
		localparam longint unsigned CUR   = longint'(brk_at(TAB, COL, r));
		localparam longint unsigned PREV  = (r == 0) ? 64'd0 :
			longint'(brk_at(TAB, COL, r - 1));
		localparam longint unsigned STEP  = (CUR > PREV) ? CUR - PREV : 64'd1;
		localparam longint unsigned RECIP =
			((64'd1 << (FRAC_BITS + SHIFT)) + STEP - 64'd1) / STEP;

		assign below[r]   = CMP_W'(value) < CMP_W'(CUR);
		assign base_r[r]  = CMP_W'(PREV);
		assign recip_r[r] = M_W'(RECIP);

		if (r == 0) begin : g_head
			assign first[r] = below[r];
		end else begin : g_tail
			assign first[r] = below[r] & ~below[r-1];
		end
	end

	// Pick the span that holds the value; past the last breakpoint the index
	// saturates and the fraction is zero.
	always_comb begin
		base  = '0;
		recip = '0;
		idx   = IDX_W'(ROWS);
		for (int r = 0; r < ROWS; r++) begin
			if (first[r]) begin
				base  = base_r[r];
				recip = recip_r[r];
				idx   = IDX_W'(r);
			end
		end
	end

	// Offset divided by the span, as a multiply by its reciprocal.
	assign diff    = CMP_W'(value) - base;
	assign product = P_W'(diff[STEP_L-1:0]) * P_W'(recip);
	assign quot    = product[SHIFT +: FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			factor_s2 <= {idx, quot};
		end
	end

endmodule

/* design/lle_level.sv */
module lle_level #(
	parameter int NUM       = 4,
	parameter int ROWS      = lle_pkg::CPU_ROWS_DEF,
	parameter int FRAC_BITS = lle_pkg::FRAC_BITS_DEF
) (
	input  logic [NUM-1:0][lle_pkg::IDX_W+FRAC_BITS-1:0] factors,
	output logic [lle_pkg::IDX_W-1:0]                    level
);
	import lle_pkg::*;

	localparam int FAC_W   = IDX_W + FRAC_BITS;
	localparam int SUM_W   = FAC_W + $clog2(NUM);
	localparam int WHOLE_W = SUM_W - FRAC_BITS;

	logic [SUM_W-1:0]   total;
	logic [WHOLE_W-1:0] whole;

	// Sum the factors in full precision.
	always_comb begin
		total = '0;
		for (int i = 0; i < NUM; i++) begin
			total = total + SUM_W'(factors[i]);
		end
	end

	// Integer part of the sum, clamped to the row count.
	assign whole = total[SUM_W-1:FRAC_BITS];
	assign level = (whole > WHOLE_W'(ROWS)) ? IDX_W'(ROWS) : whole[IDX_W-1:0];

endmodule

/* design/load_level_estimator.sv */
// A result passes through the input, factor and result registers.
// Throughput: one item per cycle; the stage that maps each count through its
// breakpoint list and multiplies by a span reciprocal sets the clock period.
// The whole pipeline holds while a finished result waits to be taken.
// Reset empties the pipeline and marks both levels as not yet reported.
module load_level_estimator #(
	parameter int CPU_ROWS  = lle_pkg::CPU_ROWS_DEF,
	parameter int GPU_ROWS  = lle_pkg::GPU_ROWS_DEF,
	parameter int FRAC_BITS = lle_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [lle_pkg::NODE_W-1:0]        node_count,
	input  logic [lle_pkg::PARTICLE_W-1:0]    particle_count,
	input  logic [lle_pkg::ACTION_W-1:0]      action_count,
	input  logic [lle_pkg::AUDIO_W-1:0]       audio_count,
	input  logic [lle_pkg::VERTEX_W-1:0]      vertex_count,
	input  logic [lle_pkg::DRAW_W-1:0]        draw_count,
	input  logic                              force_report,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [lle_pkg::PROC_GRADE_W-1:0]  proc_grade,
	output logic [lle_pkg::GFX_GRADE_W-1:0]   gfx_grade,
	output logic                              report
);
	import lle_pkg::*;

	localparam int FAC_W = IDX_W + FRAC_BITS;

	logic                     advance;
	logic                     valid_s1;
	logic                     valid_s2;
	logic [NODE_W-1:0]        node_s1;
	logic [PARTICLE_W-1:0]    particle_s1;
	logic [ACTION_W-1:0]      action_s1;
	logic [AUDIO_W-1:0]       audio_s1;
	logic [VERTEX_W-1:0]      vertex_s1;
	logic [DRAW_W-1:0]        draw_s1;
	logic                     force_s1;
	logic                     force_s2;
	logic [CPU_COLS-1:0][FAC_W-1:0] cpu_fac_s2;
	logic [GPU_COLS-1:0][FAC_W-1:0] gpu_fac_s2;
	logic [IDX_W-1:0]         cpu_full;
	logic [IDX_W-1:0]         gpu_full;
	logic [PROC_GRADE_W-1:0]  cpu_new;
	logic [GFX_GRADE_W-1:0]   gpu_new;
	logic [STATE_W-1:0]       last_cpu_eff;
	logic [STATE_W-1:0]       last_gpu_eff;
	logic                     changed;
	logic [STATE_W-1:0]       last_cpu_q;
	logic [STATE_W-1:0]       last_gpu_q;
	logic                     out_valid_q;
	logic [PROC_GRADE_W-1:0]  proc_grade_q;
	logic [GFX_GRADE_W-1:0]   gfx_grade_q;
	logic                     report_q;

	// The pipeline moves whenever the result register is free or being read.
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	// Valid flags of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (advance) begin
			node_s1     <= node_count;
			particle_s1 <= particle_count;
			action_s1   <= action_count;
			audio_s1    <= audio_count;
			vertex_s1   <= vertex_count;
			draw_s1     <= draw_count;
			force_s1    <= force_report;
			force_s2    <= force_s1;
		end
	end

	// Processor factors.
	lle_factor #(.TAB(TAB_CPU), .COL(COL_NODE), .ROWS(CPU_ROWS),
		.FRAC_BITS(FRAC_BITS), .VALUE_W(NODE_W)) u_node (
		.clk(clk), .en(advance), .value(node_s1), .factor_s2(cpu_fac_s2[0])
	);
	lle_factor #(.TAB(TAB_CPU), .COL(COL_PARTICLE), .ROWS(CPU_ROWS),
		.FRAC_BITS(FRAC_BITS), .VALUE_W(PARTICLE_W)) u_particle (
		.clk(clk), .en(advance), .value(particle_s1), .factor_s2(cpu_fac_s2[1])
	);
	lle_factor #(.TAB(TAB_CPU), .COL(COL_ACTION), .ROWS(CPU_ROWS),
		.FRAC_BITS(FRAC_BITS), .VALUE_W(ACTION_W)) u_action (
		.clk(clk), .en(advance), .value(action_s1), .factor_s2(cpu_fac_s2[2])
	);
	lle_factor #(.TAB(TAB_CPU), .COL(COL_AUDIO), .ROWS(CPU_ROWS),
		.FRAC_BITS(FRAC_BITS), .VALUE_W(AUDIO_W)) u_audio (
		.clk(clk), .en(advance), .value(audio_s1), .factor_s2(cpu_fac_s2[3])
	);

	// Graphics factors.
	lle_factor #(.TAB(TAB_GPU), .COL(COL_VERTEX), .ROWS(GPU_ROWS),
		.FRAC_BITS(FRAC_BITS), .VALUE_W(VERTEX_W)) u_vertex (
		.clk(clk), .en(advance), .value(vertex_s1), .factor_s2(gpu_fac_s2[0])
	);
	lle_factor #(.TAB(TAB_GPU), .COL(COL_DRAW), .ROWS(GPU_ROWS),
		.FRAC_BITS(FRAC_BITS), .VALUE_W(DRAW_W)) u_draw (
		.clk(clk), .en(advance), .value(draw_s1), .factor_s2(gpu_fac_s2[1])
	);

	// Level grading.
	lle_level #(.NUM(CPU_COLS), .ROWS(CPU_ROWS), .FRAC_BITS(FRAC_BITS)) u_proc_grade (
		.factors(cpu_fac_s2), .level(cpu_full)
	);
	lle_level #(.NUM(GPU_COLS), .ROWS(GPU_ROWS), .FRAC_BITS(FRAC_BITS)) u_gfx_grade (
		.factors(gpu_fac_s2), .level(gpu_full)
	);

	assign cpu_new = cpu_full[PROC_GRADE_W-1:0];
	assign gpu_new = gpu_full[GFX_GRADE_W-1:0];

	// A forced report forgets the last reported pair before comparing.
	assign last_cpu_eff = force_s2 ? NONE_REPORTED : last_cpu_q;
	assign last_gpu_eff = force_s2 ? NONE_REPORTED : last_gpu_q;
	assign changed = (STATE_W'(cpu_new) != last_cpu_eff) ||
		(STATE_W'(gpu_new) != last_gpu_eff);

	// Last reported pair, updated as each result enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cpu_q <= NONE_REPORTED;
			last_gpu_q <= NONE_REPORTED;
		end else if (advance && valid_s2) begin
			if (changed) begin
				last_cpu_q <= STATE_W'(cpu_new);
				last_gpu_q <= STATE_W'(gpu_new);
			end else if (force_s2) begin
				last_cpu_q <= NONE_REPORTED;
				last_gpu_q <= NONE_REPORTED;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (advance) begin
			proc_grade_q <= cpu_new;
			gfx_grade_q  <= gpu_new;
			report_q     <= changed;
		end
	end

	assign out_valid  = out_valid_q;
	assign proc_grade = proc_grade_q;
	assign gfx_grade  = gfx_grade_q;
	assign report     = report_q;

`ifndef SYNTH
	// The held result always matches the last reported pair.
	a_state_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (last_cpu_q == STATE_W'(proc_grade_q)) &&
			(last_gpu_q == STATE_W'(gfx_grade_q)))
		else $error("reported pair does not match the held result");

	// A forced item always leaves with its report flag set.
	a_force_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s2 && force_s2) |=> (out_valid_q && report_q))
		else $error("forced item was not reported");

	// An item in the last stage reaches the output when the pipeline moves.
	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s2) |=> out_valid_q)
		else $error("item lost between the last stage and the output");
`endif

endmodule
